@@ src/assert_macros.svh @@
// assertion macros shared by the table rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define TSOT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be true outside reset
`define TSOT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ src/tsot_pkg.sv @@
// shared types and constants of the self-organizing table
package tsot_pkg;

	localparam int unsigned TSOT_DEPTH = 16;
	localparam int unsigned OPCODE_W   = 2;
	localparam int unsigned SLOT_W     = 4;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned ENTRIES_W  = 5;
	localparam int unsigned COUNT_W    = 5;

	typedef enum logic [OPCODE_W-1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_SEARCH = 2'd2,
		OP_NOP    = 2'd3
	} tsot_op_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic wr_entry;
		logic rd_issue;
		logic scan_start;
		logic scan_issue;
		logic flush;
		logic out_load;
	} tsot_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		tsot_op_t op;
		logic     limit_zero;
		logic     scan_last;
		logic     out_free;
	} tsot_sts_t;

endpackage

@@ src/tsot_if.sv @@
// channel interfaces: request items, result items, configuration writes
interface tsot_req_if;
	logic                                valid;
	logic                                ready;
	logic [tsot_pkg::OPCODE_W-1:0]       opcode;
	logic [tsot_pkg::SLOT_W-1:0]         slot_index;
	logic signed [tsot_pkg::DATA_W-1:0]  entry_value;
	logic signed [tsot_pkg::DATA_W-1:0]  search_key;

	modport source (output valid, opcode, slot_index, entry_value, search_key, input ready);
	modport sink (input valid, opcode, slot_index, entry_value, search_key, output ready);
endinterface

interface tsot_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [tsot_pkg::COUNT_W-1:0]        match_count;
	logic signed [tsot_pkg::DATA_W-1:0]  read_value;

	modport source (output valid, match_count, read_value, input ready);
	modport sink (input valid, match_count, read_value, output ready);
endinterface

interface tsot_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [tsot_pkg::ENTRIES_W-1:0]      entries_in_use;

	modport source (output valid, entries_in_use, input ready);
	modport sink (input valid, entries_in_use, output ready);
endinterface

@@ src/tsot_ctrl.sv @@
// controller state machine of the self-organizing table
`include "assert_macros.svh"

module tsot_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tsot_pkg::tsot_sts_t sts,
	output tsot_pkg::tsot_cmd_t cmd
);
	import tsot_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_EXEC  = 6'b000010,
		ST_SCAN  = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_FLUSH = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (sts.op)
					OP_WRITE: begin
						cmd.wr_entry = 1'b1;
						state_nxt    = ST_DONE;
					end
					OP_READ: begin
						cmd.rd_issue = 1'b1;
						state_nxt    = ST_DONE;
					end
					OP_SEARCH: begin
						cmd.scan_start = 1'b1;
						state_nxt      = sts.limit_zero ? ST_DONE : ST_SCAN;
					end
					default: begin
						state_nxt = ST_DONE;
					end
				endcase
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (sts.scan_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_FLUSH;
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	`TSOT_ASSERT(a_accept_to_exec, clk, arst_n, (state_q == ST_IDLE && in_valid) |=> (state_q == ST_EXEC), "accepted item did not start execution")

endmodule

@@ src/tsot_dp.sv @@
// datapath: table memory, scan pointer, swap logic and result register
`include "assert_macros.svh"

module tsot_dp #(
	parameter int unsigned TABLE_DEPTH = tsot_pkg::TSOT_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [tsot_pkg::ENTRIES_W-1:0]      cfg_entries,
	input  logic [tsot_pkg::OPCODE_W-1:0]       opcode,
	input  logic [tsot_pkg::SLOT_W-1:0]         slot_index,
	input  logic signed [tsot_pkg::DATA_W-1:0]  entry_value,
	input  logic signed [tsot_pkg::DATA_W-1:0]  search_key,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [tsot_pkg::COUNT_W-1:0]        match_count,
	output logic signed [tsot_pkg::DATA_W-1:0]  read_value,
	input  tsot_pkg::tsot_cmd_t                 cmd,
	output tsot_pkg::tsot_sts_t                 sts
);
	import tsot_pkg::*;

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned XW = (CW > SLOT_W) ? CW : SLOT_W;
	localparam int unsigned LW = (CW > ENTRIES_W) ? CW : ENTRIES_W;

	logic [ENTRIES_W-1:0]     entries_q;
	tsot_op_t                 op_q;
	logic [SLOT_W-1:0]        slot_q;
	logic signed [DATA_W-1:0] value_q;
	logic signed [DATA_W-1:0] key_q;

	logic signed [DATA_W-1:0] mem [TABLE_DEPTH];
	logic signed [DATA_W-1:0] rd_data_s1;
	logic [CW-1:0]            rd_idx_q;
	logic [AW-1:0]            cmp_idx_s1;
	logic                     scan_vld_s1;
	logic signed [DATA_W-1:0] prev_q;
	logic [COUNT_W-1:0]       count_q;

	logic                     out_valid_q;
	logic [COUNT_W-1:0]       match_count_q;
	logic signed [DATA_W-1:0] read_value_q;

	logic [XW-1:0]            slot_x;
	logic                     slot_in_range;
	logic [AW-1:0]            slot_addr;
	logic [LW-1:0]            ent_x;
	logic [CW-1:0]            limit;
	logic [CW-1:0]            lim_m1;
	logic                     match;
	logic                     cmp_wr;
	logic                     wr_entry_en;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic signed [DATA_W-1:0] wr_data;
	logic                     rd_en;
	logic [AW-1:0]            rd_addr;

	// slot range and scan limit
	assign slot_x        = XW'(slot_q);
	assign slot_in_range = slot_x < XW'(TABLE_DEPTH);
	assign slot_addr     = slot_x[AW-1:0];
	assign ent_x         = LW'(entries_q);
	assign limit         = (ent_x > LW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(ent_x);
	assign lim_m1        = limit - CW'(1);

	// compare of the slot read last cycle; slot i-1 gets its final value now
	assign match       = rd_data_s1 == key_q;
	assign cmp_wr      = scan_vld_s1 && (cmp_idx_s1 != '0);
	assign wr_entry_en = cmd.wr_entry && slot_in_range;

	// write port select
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cmp_idx_s1 - AW'(1);
		wr_data = match ? key_q : prev_q;
		if (wr_entry_en) begin
			wr_en   = 1'b1;
			wr_addr = slot_addr;
			wr_data = value_q;
		end else if (cmp_wr) begin
			wr_en = 1'b1;
		end else if (cmd.flush) begin
			wr_en   = 1'b1;
			wr_addr = lim_m1[AW-1:0];
			wr_data = prev_q;
		end
	end

	// read port select
	assign rd_en   = cmd.scan_issue || (cmd.rd_issue && slot_in_range);
	assign rd_addr = cmd.scan_issue ? rd_idx_q[AW-1:0] : slot_addr;

	// table memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= tsot_op_t'(opcode);
			slot_q  <= slot_index;
			value_q <= entry_value;
			key_q   <= search_key;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
		end else if (cfg_valid) begin
			entries_q <= cfg_entries;
		end
	end

	// scan pointer, match count and carried slot value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			scan_vld_s1 <= 1'b0;
			count_q     <= '0;
		end else begin
			scan_vld_s1 <= cmd.scan_issue;
			if (cmd.scan_start) begin
				rd_idx_q <= '0;
				count_q  <= '0;
			end else if (cmd.scan_issue) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (scan_vld_s1 && match) begin
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_issue) begin
			cmp_idx_s1 <= rd_idx_q[AW-1:0];
		end
		// on a swap slot i now holds the old slot i-1 value
		if (scan_vld_s1 && !(match && cmp_wr)) begin
			prev_q <= rd_data_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			match_count_q <= (op_q == OP_SEARCH) ? count_q : '0;
			read_value_q  <= (op_q == OP_READ && slot_in_range) ? rd_data_s1 : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign match_count = match_count_q;
	assign read_value  = read_value_q;

	// status to the controller
	assign sts.op         = op_q;
	assign sts.limit_zero = limit == '0;
	assign sts.scan_last  = rd_idx_q == lim_m1;
	assign sts.out_free   = !out_valid_q || out_ready;

	`TSOT_ASSERT(a_one_writer, clk, arst_n, $onehot0({wr_entry_en, cmp_wr, cmd.flush}), "two writers on the table port")
	`TSOT_ASSERT(a_scan_is_search, clk, arst_n, scan_vld_s1 |-> (op_q == OP_SEARCH), "scan compare outside a search")
	`TSOT_NEVER(a_result_overrun, clk, arst_n, cmd.out_load && out_valid_q && !out_ready, "result register overwritten")

endmodule

@@ src/transpose_self_organizing_table.sv @@
// Self-organizing table of signed 32-bit entries using the transpose rule. One item is
// processed at a time. A write, read or no-op passes from an execute state to a done
// state, where its result enters the output register. A search with slots in use also
// passes through a scan state, a drain state and a flush state on the way; with no slots
// in use it goes from execute straight to done. The table memory has one read port and one
// write port. It is scanned one slot per cycle, and swaps are written back on the fly.
// After the scan, a drain state compares the last slot and a flush state writes it back.
// The next item can be taken in the cycle after the result enters the output register,
// even if that result has not been consumed yet. A result still waiting in the output
// register holds the following one back until it is taken.
// Entries read or searched before ever being written return undefined data.
module transpose_self_organizing_table #(
	parameter int unsigned TABLE_DEPTH = tsot_pkg::TSOT_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	tsot_req_if.sink   req,
	tsot_rsp_if.source rsp,
	tsot_cfg_if.sink   cfg
);
	import tsot_pkg::*;

	tsot_cmd_t cmd;
	tsot_sts_t sts;

	// configuration writes are always taken
	assign cfg.ready = 1'b1;

	tsot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tsot_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg.valid),
		.cfg_entries (cfg.entries_in_use),
		.opcode      (req.opcode),
		.slot_index  (req.slot_index),
		.entry_value (req.entry_value),
		.search_key  (req.search_key),
		.out_ready   (rsp.ready),
		.out_valid   (rsp.valid),
		.match_count (rsp.match_count),
		.read_value  (rsp.read_value),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

@@ test/tsot_checker.sv @@
`timescale 1ns / 100ps
// checker for the self-organizing table: predicts every answer and compares it
module tsot_checker (
	input  logic clk,
	input  logic arst_n,
	tsot_req_if  req,
	tsot_rsp_if  rsp,
	tsot_cfg_if  cfg,
	output int   fail_count,
	output int   pending
);
	import tsot_pkg::*;

	typedef struct packed {
		logic [COUNT_W-1:0] hits;
		logic [DATA_W-1:0]  word;
	} answer_t;

	// shadow copy of the table and of the search span
	logic [DATA_W-1:0]    shadow_tbl [TSOT_DEPTH];
	logic [ENTRIES_W-1:0] span;
	answer_t              answer_q [$];

	// applies one item to the shadow table and returns its answer
	function automatic answer_t apply_op(tsot_op_t op, logic [SLOT_W-1:0] slot,
		logic [DATA_W-1:0] word, logic [DATA_W-1:0] key);
		answer_t           a;
		int unsigned       lim;
		int unsigned       i;
		logic [DATA_W-1:0] t;
		a = '0;
		case (op)
		OP_WRITE: begin
			if (slot < TSOT_DEPTH)
				shadow_tbl[slot] = word;
		end
		OP_READ: begin
			if (slot < TSOT_DEPTH)
				a.word = shadow_tbl[slot];
		end
		OP_SEARCH: begin
			// oversized span is clipped to the table depth
			lim = (span > TSOT_DEPTH) ? TSOT_DEPTH : span;
			// each hit moves one slot toward the front, slot 0 stays put
			for (i = 0; i < lim; i++) begin
				if (shadow_tbl[i] == key) begin
					if (i > 0) begin
						t = shadow_tbl[i];
						shadow_tbl[i] = shadow_tbl[i - 1];
						shadow_tbl[i - 1] = t;
					end
					a.hits = a.hits + 1'b1;
				end
			end
		end
		default: ;
		endcase
		return a;
	endfunction

	// watch the channels, predict on request, compare on result
	always @(posedge clk or negedge arst_n) begin : watch
		answer_t want;
		int      errs;
		if (!arst_n) begin
			span <= '0;
			answer_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			errs = 0;
			if (cfg.valid && cfg.ready)
				span <= cfg.entries_in_use;
			// results first so a same-edge request cannot cover a spurious one
			if (rsp.valid && rsp.ready) begin
				if (answer_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual count %0d value %0d",
						$time, rsp.match_count, rsp.read_value);
					errs++;
				end else begin
					want = answer_q.pop_front();
					if (rsp.match_count !== want.hits) begin
						$display("%0t: match_count expected %0d actual %0d",
							$time, want.hits, rsp.match_count);
						errs++;
					end
					if (rsp.read_value !== want.word) begin
						$display("%0t: read_value expected %0d actual %0d",
							$time, $signed(want.word), rsp.read_value);
						errs++;
					end
				end
			end
			if (req.valid && req.ready)
				answer_q.push_back(apply_op(tsot_op_t'(req.opcode), req.slot_index,
					req.entry_value, req.search_key));
			fail_count <= fail_count + errs;
			pending <= answer_q.size();
		end
	end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// testbench top: clock, reset, item stimulus, watchdog and verdict
module tb;
	import tsot_pkg::*;

	localparam int STALL_MAX    = 12;
	localparam int QUIET_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 24;
	localparam int ITEM_GOAL    = 1900;
	localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] WORD_MAX = 32'h7fff_ffff;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   quiet_cycles = 0;
	bit   send_gaps = 1'b0;
	bit   take_gaps = 1'b0;

	tsot_req_if req ();
	tsot_rsp_if rsp ();
	tsot_cfg_if cfg ();

	transpose_self_organizing_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	tsot_checker i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side: optional random stall before each item
	initial begin : result_side
		int stall;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = take_gaps ? $urandom_range(0, STALL_MAX) : 0;
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one request item, with an optional gap in front
	task automatic send_item(tsot_op_t op, logic [SLOT_W-1:0] slot,
		logic [DATA_W-1:0] word, logic [DATA_W-1:0] key);
		int gap;
		gap = send_gaps ? $urandom_range(0, STALL_MAX) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.slot_index <= slot;
		req.entry_value <= word;
		req.search_key <= key;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	// drain the block, then write the search span
	task automatic set_span(logic [ENTRIES_W-1:0] n);
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.entries_in_use <= n;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
	endtask

	// words drawn mostly from a small pool so searches hit often
	function automatic logic [DATA_W-1:0] pick_word();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			case ($urandom_range(0, 3))
			0: return 32'd5;
			1: return -32'sd7;
			2: return 32'd0;
			default: return 32'hffff_ffff;
			endcase
		end
		if (r == 6)
			return WORD_MIN;
		if (r == 7)
			return WORD_MAX;
		return $urandom();
	endfunction

	initial begin : stimulus
		int                   s;
		int                   r;
		int                   n;
		int                   total;
		logic [1:0]           mode;
		logic [ENTRIES_W-1:0] span;
		logic [DATA_W-1:0]    word;
		tsot_op_t             op;

		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.opcode <= OP_NOP;
		req.slot_index <= '0;
		req.entry_value <= '0;
		req.search_key <= '0;
		cfg.valid <= 1'b0;
		cfg.entries_in_use <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty span, unused opcode, fill every slot, read the first and last
		set_span('0);
		send_item(OP_SEARCH, '0, '0, '0);
		send_item(OP_NOP, 4'hf, WORD_MAX, WORD_MIN);
		for (s = 0; s < TSOT_DEPTH; s++) begin
			case (s)
			0: word = WORD_MIN;
			1: word = WORD_MAX;
			2: word = 32'hffff_ffff;
			3: word = 32'd0;
			4, 5, 6: word = 32'd5;
			default: word = 32'd1000 + s;
			endcase
			send_item(OP_WRITE, SLOT_W'(s), word, '0);
		end
		send_item(OP_READ, '0, '0, '0);
		send_item(OP_READ, 4'hf, '0, '0);

		// directed: full span, run of equal keys, hit at the front, miss
		set_span(ENTRIES_W'(TSOT_DEPTH));
		send_item(OP_SEARCH, '0, '0, 32'd5);
		send_item(OP_SEARCH, '0, '0, WORD_MIN);
		send_item(OP_SEARCH, '0, '0, WORD_MAX);
		send_item(OP_SEARCH, '0, '0, 32'd12345);
		send_item(OP_READ, '0, '0, '0);

		// directed: span above the table depth
		set_span(5'd31);
		send_item(OP_SEARCH, '0, '0, 32'hffff_ffff);

		// random phases, each with its own span and idling mode
		total = 0;
		while (total < ITEM_GOAL) begin
			r = $urandom_range(0, 9);
			case (r)
			0: span = '0;
			1: span = 5'd1;
			2, 3: span = ENTRIES_W'(TSOT_DEPTH);
			4: span = ENTRIES_W'($urandom_range(TSOT_DEPTH + 1, 31));
			default: span = ENTRIES_W'($urandom_range(2, TSOT_DEPTH - 1));
			endcase
			set_span(span);
			mode = 2'($urandom_range(0, 3));
			send_gaps = mode[0];
			take_gaps = mode[1];
			n = $urandom_range(40, 160);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 35)
					op = OP_SEARCH;
				else if (r < 65)
					op = OP_WRITE;
				else if (r < 93)
					op = OP_READ;
				else
					op = OP_NOP;
				send_item(op, SLOT_W'($urandom_range(0, TSOT_DEPTH - 1)), pick_word(),
					pick_word());
			end
			total += n;
		end

		// wait for every answer and for strays, then give the verdict
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
